FILE: rtl/core/rsp_pkg.sv
`timescale 1ns / 1ps
package rsp_pkg;

  // Field widths
  localparam int ELEM_W    = 16;
  localparam int COORD_W   = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W     = 28;
  localparam int RUN_W     = 22;
  localparam int STATUS_W  = 2;
  localparam int S_DATA_W  = 40;
  localparam int M_DATA_W  = 32;

  // Default geometry
  localparam int DEF_MAX_ROWS     = 64;
  localparam int DEF_MAX_COLS     = 64;
  localparam int DEF_ELEMENT_BITS = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RECT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd2;

endpackage

FILE: rtl/core/rsp_ram.sv
`timescale 1ns / 1ps
module rsp_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] ra_addr_i,
  input  logic [$clog2(DEPTH)-1:0] rb_addr_i,
  output logic [WIDTH-1:0]         ra_data_o,
  output logic [WIDTH-1:0]         rb_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    ra_data_o <= mem[ra_addr_i];
    rb_data_o <= mem[rb_addr_i];
  end

endmodule

FILE: rtl/core/rect_sum_prefix_table_core.sv
`timescale 1ns / 1ps
// Load beat: read of the entry above, then write back into the table memory.
// Query beat: two passes over the two memory read ports (ST_Q_AB, ST_Q_CD); the result is
// registered in ST_Q_CD or held in ST_HOLD, and the next beat is taken back in ST_IDLE. A
// rejected query answers from ST_IDLE while the output is free, else via ST_HOLD. A pending
// result only stalls a query answer, not further loads. Reset (rst_ni low, asynchronous)
// clears load position, running sum and output valid; dimensions go to min(MAX_*, 64).
module rect_sum_prefix_table_core #(
  parameter int MAX_ROWS     = rsp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS     = rsp_pkg::DEF_MAX_COLS,
  parameter int ELEMENT_BITS = rsp_pkg::DEF_ELEMENT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // element, top_row, left_col, bottom_row, right_col
  input  logic [rsp_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // cmd
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // rect_sum, zero padding
  output logic [rsp_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // status
  output logic [rsp_pkg::STATUS_W-1:0]   m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rsp_pkg::CFG_W-1:0]      cfg_data_i
);
  import rsp_pkg::*;

  localparam int RB  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CB  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW  = RB + CB;
  localparam int RLW = $clog2(MAX_ROWS + 1);
  localparam int CLW = $clog2(MAX_COLS + 1);
  localparam int QW  = ((RLW > CLW) ? RLW : CLW) + COORD_W;
  localparam int EB  = (ELEMENT_BITS < ELEM_W) ? ELEMENT_BITS : ELEM_W;
  localparam logic [ELEM_W-1:0] ElemMask = ELEM_W'((33'(1) << EB) - 33'(1));
  localparam logic [RLW-1:0] RowsReset = RLW'((MAX_ROWS < 64) ? MAX_ROWS : 64);
  localparam logic [CLW-1:0] ColsReset = CLW'((MAX_COLS < 64) ? MAX_COLS : 64);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_Q_AB,
    ST_Q_CD,
    ST_HOLD
  } state_e;

  function automatic logic [RLW-1:0] clamp_rows(logic [CFG_W-1:0] v);
    if (v == '0) return RLW'(1);
    if (32'(v) > MAX_ROWS) return RLW'(MAX_ROWS);
    return RLW'(v);
  endfunction

  function automatic logic [CLW-1:0] clamp_cols(logic [CFG_W-1:0] v);
    if (v == '0) return CLW'(1);
    if (32'(v) > MAX_COLS) return CLW'(MAX_COLS);
    return CLW'(v);
  endfunction

  state_e               state_q;
  logic [RLW-1:0]       rows_q;
  logic [CLW-1:0]       cols_q;
  logic [RLW-1:0]       load_row_q;
  logic [CB-1:0]        load_col_q;
  logic [RUN_W-1:0]     run_q;
  logic [COORD_W-1:0]   top_q, left_q, right_q;
  logic                 top_nz_q, left_nz_q;
  logic [SUM_W-1:0]     partial_q;
  logic [SUM_W-1:0]     res_sum_q;
  logic [STATUS_W-1:0]  res_status_q;
  logic                 m_valid_q;
  logic [SUM_W-1:0]     m_sum_q;
  logic [STATUS_W-1:0]  m_status_q;

  logic                 in_beat;
  logic                 out_free;
  logic                 out_load;
  logic                 load_done;
  logic                 rect_bad;
  logic [ELEM_W-1:0]    in_element;
  logic [COORD_W-1:0]   in_top, in_left, in_bottom, in_right;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_ra_addr, ram_rb_addr;
  logic [SUM_W-1:0]     ram_wdata, ram_ra_data, ram_rb_data;
  logic [SUM_W-1:0]     above;
  logic [SUM_W-1:0]     query_sum;
  logic [CLW-1:0]       col_next;

  assign in_element = s_axis_tdata[15:0];
  assign in_top     = s_axis_tdata[21:16];
  assign in_left    = s_axis_tdata[27:22];
  assign in_bottom  = s_axis_tdata[33:28];
  assign in_right   = s_axis_tdata[39:34];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign load_done     = (load_row_q >= rows_q);
  assign rect_bad      = (in_top > in_bottom) || (in_left > in_right)
                      || (QW'(in_bottom) >= QW'(rows_q))
                      || (QW'(in_right) >= QW'(cols_q));
  assign out_load      = out_free
                      && (((state_q == ST_IDLE) && in_beat && (s_axis_tuser == CMD_QUERY)
                           && (!load_done || rect_bad))
                          || (state_q == ST_Q_CD) || (state_q == ST_HOLD));

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_DATA_W'(m_sum_q);
  assign m_axis_tuser  = m_status_q;

  // Table memory addressing
  always_comb begin
    ram_ra_addr = {RB'(in_bottom), CB'(in_right)};
    ram_rb_addr = {RB'(in_bottom), CB'(in_left - COORD_W'(1))};
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tuser == CMD_LOAD) begin
          ram_ra_addr = {RB'(load_row_q - RLW'(1)), load_col_q};
        end
      end
      ST_Q_AB: begin
        ram_ra_addr = {RB'(top_q - COORD_W'(1)), CB'(right_q)};
        ram_rb_addr = {RB'(top_q - COORD_W'(1)), CB'(left_q - COORD_W'(1))};
      end
      default: ;
    endcase
  end

  assign above     = (load_row_q != '0) ? ram_ra_data : '0;
  assign ram_we    = (state_q == ST_LOAD_WR);
  assign ram_waddr = {RB'(load_row_q), load_col_q};
  assign ram_wdata = above + SUM_W'(run_q);
  assign col_next  = CLW'(load_col_q) + CLW'(1);
  assign query_sum = partial_q - (top_nz_q ? ram_ra_data : '0)
                   + ((top_nz_q && left_nz_q) ? ram_rb_data : '0);

  rsp_ram #(
    .WIDTH (SUM_W),
    .DEPTH (2 ** AW)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .ra_addr_i (ram_ra_addr),
    .rb_addr_i (ram_rb_addr),
    .ra_data_o (ram_ra_data),
    .rb_data_o (ram_rb_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rows_q       <= RowsReset;
      cols_q       <= ColsReset;
      load_row_q   <= '0;
      load_col_q   <= '0;
      run_q        <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      // drop valid once the beat is taken, unless a new answer replaces it
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            if (s_axis_tuser == CMD_LOAD) begin
              // drop loads past the matrix
              if (!load_done) begin
                run_q   <= run_q + RUN_W'(in_element & ElemMask);
                state_q <= ST_LOAD_WR;
              end
            end else if (!load_done || rect_bad) begin
              if (out_free) begin
                m_valid_q  <= 1'b1;
                m_sum_q    <= '0;
                m_status_q <= load_done ? STATUS_BAD_RECT : STATUS_NOT_LOADED;
              end else begin
                res_sum_q    <= '0;
                res_status_q <= load_done ? STATUS_BAD_RECT : STATUS_NOT_LOADED;
                state_q      <= ST_HOLD;
              end
            end else begin
              top_q     <= in_top;
              left_q    <= in_left;
              right_q   <= in_right;
              top_nz_q  <= (in_top != '0);
              left_nz_q <= (in_left != '0);
              state_q   <= ST_Q_AB;
            end
          end
        end
        ST_LOAD_WR: begin
          if (col_next >= cols_q) begin
            load_col_q <= '0;
            load_row_q <= load_row_q + RLW'(1);
            run_q      <= '0;
          end else begin
            load_col_q <= CB'(col_next);
          end
          state_q <= ST_IDLE;
        end
        ST_Q_AB: begin
          partial_q <= ram_ra_data - (left_nz_q ? ram_rb_data : '0);
          state_q   <= ST_Q_CD;
        end
        ST_Q_CD: begin
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_sum_q    <= query_sum;
            m_status_q <= STATUS_OK;
            state_q    <= ST_IDLE;
          end else begin
            res_sum_q    <= query_sum;
            res_status_q <= STATUS_OK;
            state_q      <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_sum_q    <= res_sum_q;
            m_status_q <= res_status_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // any register write restarts loading
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_ROWS: rows_q <= clamp_rows(cfg_data_i);
          REG_COLS: cols_q <= clamp_cols(cfg_data_i);
          default: ;
        endcase
        load_row_q <= '0;
        load_col_q <= '0;
        run_q      <= '0;
      end
    end
  end

endmodule

FILE: rtl/core/rsp_checker.sv
`timescale 1ns / 1ps
module rsp_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [rsp_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input  logic [rsp_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import rsp_pkg::*;

  // Rejected queries carry a zero sum
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> (m_axis_tdata[SUM_W-1:0] == '0))
    else $error("rejected result with nonzero sum");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_OK) || (m_axis_tuser == STATUS_BAD_RECT)
                      || (m_axis_tuser == STATUS_NOT_LOADED))
    else $error("undefined status code");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[M_DATA_W-1:SUM_W] == '0))
    else $error("padding bits set");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind rect_sum_prefix_table_core rsp_checker u_rsp_checker (.*);

FILE: bench/tb_rect_sum_prefix_table_core.sv
`timescale 1ns / 1ps
module tb_rect_sum_prefix_table_core;
  import rsp_pkg::*;

  localparam int ROWS_MAX      = DEF_MAX_ROWS;
  localparam int COLS_MAX      = DEF_MAX_COLS;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1700;

  typedef struct {
    logic [SUM_W-1:0]    rect_sum;
    logic [STATUS_W-1:0] status;
  } rect_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                 s_axis_tuser  = CMD_LOAD;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = REG_ROWS;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  // Shadow of the summed-area table and the load position
  logic [SUM_W-1:0] sat_tbl [ROWS_MAX*COLS_MAX];
  logic [CFG_W-1:0] rows_cfg = CFG_W'(ROWS_MAX);
  logic [CFG_W-1:0] cols_cfg = CFG_W'(COLS_MAX);
  int               fill_row = 0;
  int               fill_col = 0;
  logic [RUN_W-1:0] row_acc  = '0;
  rect_result_t     sums_due_q[$];

  int err_cnt     = 0;
  int items_done  = 0;
  int stall_left  = 0;
  bit src_gaps    = 1'b1;
  bit sink_stalls = 1'b1;

  rect_sum_prefix_table_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 12);
  endfunction

  function automatic logic [ELEM_W-1:0] rand_element();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return ELEM_W'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] v, int top);
    if (v == 0) return CFG_W'(1);
    if (v > top) return CFG_W'(top);
    return v;
  endfunction

  // Entry at (r1-1, c1-1); row or column 0 is the zero border
  function automatic logic [SUM_W-1:0] corner(int r1, int c1);
    if (r1 == 0 || c1 == 0) return '0;
    return sat_tbl[(r1 - 1) * COLS_MAX + (c1 - 1)];
  endfunction

  function automatic void apply_load(logic [ELEM_W-1:0] elem);
    logic [SUM_W-1:0] above;
    if (fill_row >= rows_cfg) return;
    row_acc = row_acc + RUN_W'(elem);
    above = corner(fill_row, fill_col + 1);
    sat_tbl[fill_row * COLS_MAX + fill_col] = above + SUM_W'(row_acc);
    if (fill_col + 1 >= cols_cfg) begin
      fill_col = 0;
      fill_row++;
      row_acc = '0;
    end else begin
      fill_col++;
    end
  endfunction

  function automatic rect_result_t rect_answer(logic [COORD_W-1:0] t, l, b, r);
    rect_result_t res;
    res.rect_sum = '0;
    if (fill_row < rows_cfg) begin
      res.status = STATUS_NOT_LOADED;
    end else if (t > b || l > r || b >= rows_cfg || r >= cols_cfg) begin
      res.status = STATUS_BAD_RECT;
    end else begin
      res.status   = STATUS_OK;
      res.rect_sum = corner(b + 1, r + 1) - corner(b + 1, l) - corner(t, r + 1) + corner(t, l);
    end
    return res;
  endfunction

  // Keep tvalid high across back-to-back beats; drop it only for a gap
  task automatic send_beat(logic cmd, logic [ELEM_W-1:0] elem,
                           logic [COORD_W-1:0] t, l, b, r);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {r, b, l, t, elem};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_QUERY) sums_due_q.push_back(rect_answer(t, l, b, r));
    else apply_load(elem);
    items_done++;
  endtask

  task automatic send_load(logic [ELEM_W-1:0] elem);
    send_beat(CMD_LOAD, elem, COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic send_query(int t, l, b, r);
    send_beat(CMD_QUERY, ELEM_W'($urandom), COORD_W'(t), COORD_W'(l),
              COORD_W'(b), COORD_W'(r));
  endtask

  task automatic send_any_query();
    send_query($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
               $urandom_range(0, 63));
  endtask

  task automatic send_inside_query();
    int t, l, b, r;
    t = $urandom_range(0, rows_cfg - 1);
    b = $urandom_range(t, rows_cfg - 1);
    l = $urandom_range(0, cols_cfg - 1);
    r = $urandom_range(l, cols_cfg - 1);
    send_query(t, l, b, r);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sums_due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_ROWS) rows_cfg = clamp_dim(val, ROWS_MAX);
    else cols_cfg = clamp_dim(val, COLS_MAX);
    fill_row = 0;
    fill_col = 0;
    row_acc  = '0;
    @(posedge clk_i);
  endtask

  // Load up to max_loads elements, with the odd early query mixed in
  task automatic load_some(int max_loads, bit noisy);
    int n;
    n = 0;
    while (fill_row < rows_cfg && n < max_loads) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        send_any_query();
      end
      send_load(rand_element());
      n++;
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    rect_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sums_due_q.size() == 0) begin
        $error("unexpected result beat: rect_sum %0d status %0d",
               m_axis_tdata[SUM_W-1:0], m_axis_tuser);
        err_cnt++;
      end else begin
        want = sums_due_q.pop_front();
        if (m_axis_tdata[SUM_W-1:0] !== want.rect_sum) begin
          $error("rect_sum mismatch: expected %0d, actual %0d",
                 want.rect_sum, m_axis_tdata[SUM_W-1:0]);
          err_cnt++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Default 64 x 64 geometry straight out of reset: nothing loaded yet
  task automatic test_unloaded();
    send_query(0, 0, 63, 63);
    send_query(0, 0, 0, 0);
    send_query(63, 63, 63, 63);
    // not-loaded wins over a reversed rectangle
    send_query(5, 9, 2, 1);
  endtask

  task automatic test_register_limits();
    // zero acts as one, anything above 64 saturates
    write_reg(REG_ROWS, 7'd0);
    write_reg(REG_COLS, 7'h7F);
    for (int i = 0; i < COLS_MAX; i++) send_load((i % 2) ? '0 : '1);
    repeat (3) send_load(rand_element());
    send_query(0, 0, 0, 63);
    send_query(0, 63, 0, 63);
    send_query(0, 0, 1, 0);
    send_query(0, 10, 0, 9);
    write_reg(REG_ROWS, 7'd64);
    write_reg(REG_COLS, 7'd0);
    send_query(0, 0, 0, 0);
    load_some(30, 1'b0);
    // rewriting the same value must restart loading
    write_reg(REG_COLS, 7'd1);
    send_query(0, 0, 0, 0);
    load_some(ROWS_MAX, 1'b0);
    send_query(0, 0, 63, 0);
    send_query(10, 0, 9, 0);
    send_query(0, 0, 0, 1);
  endtask

  task automatic test_bad_rect();
    write_reg(REG_ROWS, 7'd5);
    write_reg(REG_COLS, 7'd7);
    load_some(4, 1'b0);
    send_query(0, 0, 4, 6);
    load_some(100, 1'b0);
    send_query(0, 0, 4, 6);
    send_query(4, 6, 4, 6);
    send_query(0, 0, 5, 6);
    send_query(0, 0, 4, 7);
    send_query(3, 0, 2, 6);
    send_query(0, 4, 4, 3);
    send_query(63, 63, 63, 63);
  endtask

  // Tall table at the largest element: the full sum reaches 64 * 16 * 65535
  task automatic test_full_geometry();
    write_reg(REG_ROWS, 7'd64);
    write_reg(REG_COLS, 7'd16);
    while (fill_row < rows_cfg) send_load('1);
    send_query(0, 0, 63, 15);
    send_query(63, 15, 63, 15);
    send_query(0, 0, 0, 0);
    send_query(1, 1, 62, 14);
    repeat (20) send_inside_query();
  endtask

  task automatic run_phase();
    int pick, nq;
    src_gaps    = $urandom_range(0, 3) != 0;
    sink_stalls = $urandom_range(0, 3) != 0;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      write_reg(REG_ROWS, CFG_W'($urandom_range(1, 8)));
      write_reg(REG_COLS, CFG_W'($urandom_range(1, 8)));
    end else if (pick < 18) begin
      write_reg(REG_COLS, CFG_W'($urandom_range(1, 24)));
      write_reg(REG_ROWS, CFG_W'($urandom_range(1, 24)));
    end else if (pick == 18) begin
      write_reg(REG_ROWS, CFG_W'($urandom_range(0, 127)));
      write_reg(REG_COLS, CFG_W'($urandom_range(0, 3)));
    end else begin
      write_reg(REG_COLS, CFG_W'($urandom_range(0, 127)));
      write_reg(REG_ROWS, CFG_W'($urandom_range(0, 3)));
    end
    if ($urandom_range(0, 3) == 0) begin
      send_any_query();
    end
    // abandon a partial load and start over
    if ($urandom_range(0, 7) == 0) begin
      load_some($urandom_range(0, rows_cfg * cols_cfg - 1), 1'b1);
      write_reg(REG_ROWS, rows_cfg);
      send_inside_query();
    end
    load_some(ROWS_MAX * COLS_MAX, 1'b1);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_load(rand_element());
    nq = $urandom_range(4, 24);
    repeat (nq) begin
      if ($urandom_range(0, 32) == 0) wait_idle();
      if ($urandom_range(0, 4) == 0) send_any_query();
      else send_inside_query();
    end
  endtask

  task automatic test_random_traffic();
    while (items_done < RANDOM_ITEMS) run_phase();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unloaded();
    test_register_limits();
    test_bad_rect();
    test_full_geometry();
    test_random_traffic();
    wait_idle();
    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #8000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
